/* hdl/buzzer_pattern_sequencer_top_macros.svh */
// Assertion macros for the buzzer pattern sequencer checker.
// Plain text header; no dependencies.
`ifndef BUZZER_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("buzzer sequencer check failed");

// Next-cycle implication, disabled while reset is held
`define BPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("buzzer sequencer check failed");

`endif

/* hdl/bps_pkg.sv */
// Shared types, codes and helper functions for the buzzer pattern sequencer.
// No dependencies.
`default_nettype none

package bps_pkg;

    // Command codes carried by each input beat
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_DURATION = 2'd1,
        CMD_NTIMES   = 2'd2,
        CMD_PATTERN  = 2'd3
    } cmd_t;

    localparam int unsigned PATTERN_W = 32;
    localparam int unsigned REPS_W    = 8;
    localparam int unsigned DUR_W     = 11;
    localparam int unsigned CURSOR_W  = 5;

    // Request as decoded from a command
    typedef struct packed {
        logic [PATTERN_W-1:0] bits;
        logic [REPS_W-1:0]    reps;
    } req_t;

    // Per-beat result of the player
    typedef struct packed {
        logic buzzer_on;
        logic busy;
    } res_t;

    // Divide a 13-bit value by 125: reciprocal multiply, then one correction
    function automatic logic [6:0] div125(input logic [12:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [12:0] r;
        prod = 23'(x) * 23'd524;
        q    = prod[22:16];
        r    = x - 13'(13'(q) * 13'd125);
        if (r >= 13'd125) begin
            q = q + 7'd1;
        end
        return q;
    endfunction

    // Mask of the low s bits, all ones once s reaches the word width
    function automatic logic [PATTERN_W-1:0] low_ones(input logic [6:0] s);
        logic [PATTERN_W-1:0] m;
        if (s >= 7'd32) begin
            m = '1;
        end else begin
            m = (PATTERN_W'(1) << s[4:0]) - PATTERN_W'(1);
        end
        return m;
    endfunction

    // Position of the most significant set bit, zero for an empty word
    function automatic logic [CURSOR_W-1:0] top_bit(input logic [PATTERN_W-1:0] v);
        logic [CURSOR_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < PATTERN_W; i++) begin
            if (v[i]) begin
                pos = CURSOR_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

/* hdl/buzzer_pattern_sequencer_top.sv */
// Buzzer pattern sequencer: how to use it
//  - Input channel (s_*): one command beat per item: a 16 Hz tick, a beep of
//    s_duration_ms, s_repeat_count beeps, or a raw 32-bit s_pattern_word.
//  - Result channel (m_*): one beat per command with the buzzer pin level
//    (m_buzzer_on) and whether a request is pending or playing (m_busy_res).
//  - Path: a beat passes the input register and then the result register;
//    the player state updates between the two.
//  - Throughput: one beat per cycle while m_ready stays high; the player's next-state
//    logic and the leading-one encoder are combinational between the two registers.
//  - Reset (aresetn low, synchronous): both registers empty, pattern state
//    cleared, player pin low, not busy; the result data bits are not reset.
//  - Stall: while m_ready is low the result beat holds; one more beat waits
//    in the input register, after which s_ready drops.
// Depends on bps_pkg, bps_req_decode and bps_player.
`default_nettype none

module buzzer_pattern_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_pattern_word,
    input  wire logic [10:0] s_duration_ms,
    input  wire logic [7:0]  s_repeat_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_buzzer_on,
    output logic             m_busy_res
);
    import bps_pkg::*;

    logic                 in_vld_reg;
    cmd_t                 cmd_reg;
    logic [PATTERN_W-1:0] word_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [REPS_W-1:0]    reps_reg;

    logic                 out_vld_reg;
    logic                 buzzer_reg;
    logic                 busy_reg;

    logic                 advance;
    req_t                 req;
    res_t                 res;

    // Move the held beat on when the result register is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= cmd_t'(s_command);
            word_reg <= s_pattern_word;
            dur_reg  <= s_duration_ms;
            reps_reg <= s_repeat_count;
        end
    end

    bps_req_decode u_decode (
        .cmd          (cmd_reg),
        .pattern_word (word_reg),
        .duration_ms  (dur_reg),
        .repeat_count (reps_reg),
        .req          (req)
    );

    bps_player u_player (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cmd     (cmd_reg),
        .req     (req),
        .res     (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            buzzer_reg <= res.buzzer_on;
            busy_reg   <= res.busy;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_buzzer_on = buzzer_reg;
    assign m_busy_res  = busy_reg;

endmodule

`default_nettype wire

/* hdl/bps_req_decode.sv */
// Request decoder: turns a command beat into the pattern and repeat count.
// Depends on bps_pkg.
`default_nettype none

module bps_req_decode (
    input  wire bps_pkg::cmd_t   cmd,
    input  wire logic [31:0]     pattern_word,
    input  wire logic [10:0]     duration_ms,
    input  wire logic [7:0]      repeat_count,
    output bps_pkg::req_t        req
);
    import bps_pkg::*;

    logic [6:0]           k_count;
    logic [6:0]           j_count;
    logic [PATTERN_W-1:0] k_mask;
    logic [PATTERN_W-1:0] j_mask;

    // k = 16*d/1000 = 2d/125, j = 32*d/1000 = 4d/125
    assign k_count = div125({1'b0, duration_ms, 1'b0});
    assign j_count = div125({duration_ms, 2'b00});
    assign k_mask  = low_ones(k_count);
    assign j_mask  = low_ones(j_count);

    // Select the request pattern for the command
    always_comb begin
        case (cmd)
            CMD_DURATION: begin
                req.bits = k_mask;
                req.reps = REPS_W'(1);
            end
            CMD_NTIMES: begin
                req.bits = j_mask ^ k_mask;
                req.reps = repeat_count;
            end
            CMD_PATTERN: begin
                req.bits = pattern_word;
                req.reps = REPS_W'(1);
            end
            default: begin
                req.bits = '0;
                req.reps = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bps_player.sv */
// Player: pending and active pattern state, advanced once per beat.
// Depends on bps_pkg.
`default_nettype none

module bps_player (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire bps_pkg::cmd_t cmd,
    input  wire bps_pkg::req_t req,
    output bps_pkg::res_t      res
);
    import bps_pkg::*;

    logic [PATTERN_W-1:0] pend_bits_reg, pend_bits_next;
    logic [REPS_W-1:0]    pend_reps_reg, pend_reps_next;
    logic [PATTERN_W-1:0] act_bits_reg,  act_bits_next;
    logic [REPS_W-1:0]    act_reps_reg,  act_reps_next;
    logic [CURSOR_W-1:0]  cursor_reg,    cursor_next;
    logic                 cursor_vld_reg, cursor_vld_next;
    logic                 pin_reg,       pin_next;

    logic                 load;
    logic [PATTERN_W-1:0] play_bits;
    logic [REPS_W-1:0]    play_reps;
    logic [CURSOR_W-1:0]  cur;

    // Work out the state after this beat
    always_comb begin
        pend_bits_next  = pend_bits_reg;
        pend_reps_next  = pend_reps_reg;
        act_bits_next   = act_bits_reg;
        act_reps_next   = act_reps_reg;
        cursor_next     = cursor_reg;
        cursor_vld_next = cursor_vld_reg;
        pin_next        = pin_reg;

        load      = (pend_reps_reg != '0) && (act_reps_reg == '0);
        play_bits = load ? pend_bits_reg : act_bits_reg;
        play_reps = load ? pend_reps_reg : act_reps_reg;
        cur       = cursor_vld_reg ? cursor_reg : top_bit(play_bits);

        case (cmd)
            CMD_TICK: begin
                if (load) begin
                    pend_reps_next = '0;
                    act_bits_next  = pend_bits_reg;
                    act_reps_next  = pend_reps_reg;
                end
                if (load && (pend_bits_reg == '0)) begin
                    // drop an empty pattern, keep the pin
                    act_reps_next = '0;
                end else if (play_reps == '0) begin
                    pin_next = 1'b0;
                end else begin
                    pin_next = cursor_vld_reg ? play_bits[cursor_reg] : 1'b1;
                    if (cur == '0) begin
                        cursor_next     = cur;
                        cursor_vld_next = 1'b0;
                        act_reps_next   = play_reps - REPS_W'(1);
                    end else begin
                        cursor_next     = cur - CURSOR_W'(1);
                        cursor_vld_next = 1'b1;
                    end
                end
            end
            default: begin
                // overwrite the pending request
                pend_bits_next = req.bits;
                pend_reps_next = req.reps;
            end
        endcase

        res.buzzer_on = pin_next;
        res.busy      = (pend_reps_next != '0) || (act_reps_next != '0);
    end

    // Hold state; advance only on a beat leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg  <= '0;
            pend_reps_reg  <= '0;
            act_bits_reg   <= '0;
            act_reps_reg   <= '0;
            cursor_reg     <= '0;
            cursor_vld_reg <= 1'b0;
            pin_reg        <= 1'b0;
        end else if (step) begin
            pend_bits_reg  <= pend_bits_next;
            pend_reps_reg  <= pend_reps_next;
            act_bits_reg   <= act_bits_next;
            act_reps_reg   <= act_reps_next;
            cursor_reg     <= cursor_next;
            cursor_vld_reg <= cursor_vld_next;
            pin_reg        <= pin_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bps_checker.sv */
// Port-level checker for the buzzer pattern sequencer, bound to the top level.
// Depends on buzzer_pattern_sequencer_top_macros.svh.
`default_nettype none
`include "buzzer_pattern_sequencer_top_macros.svh"

module bps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_buzzer_on,
    input wire logic        m_busy_res
);

    // Result beat holds while stalled
    `BPS_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `BPS_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_valid && !m_ready, $stable({m_buzzer_on, m_busy_res}))

    // Offered input beat stays offered until taken
    `BPS_ASSERT_NEXT(a_s_valid_hold, aclk, aresetn, s_valid && !s_ready, s_valid)

    // Input side never stalls while the result side can drain
    `BPS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `BPS_ASSERT_NOW(a_ready_when_drain, aclk, aresetn, m_ready, s_ready)

endmodule

bind buzzer_pattern_sequencer_top bps_checker u_bps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_buzzer_on (m_buzzer_on),
    .m_busy_res  (m_busy_res)
);

`default_nettype wire

/* sim/buzzer_pattern_sequencer_top_tb.sv */
// Self-checking testbench for buzzer_pattern_sequencer_top: directed and random command beats
// with random stalls on both channels, checked against a cycle-free player model.
// Depends on bps_pkg and the buzzer_pattern_sequencer_top RTL.
`default_nettype none

module buzzer_pattern_sequencer_top_tb;

    import bps_pkg::*;

    localparam int unsigned RANDOM_BEATS = 780;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] word;
        logic [10:0] dur;
        logic [7:0]  reps;
    } cmd_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_TICK;
    logic [31:0] s_pattern_word = '0;
    logic [10:0] s_duration_ms = '0;
    logic [7:0]  s_repeat_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_buzzer_on;
    logic        m_busy_res;

    cmd_beat_t   cmd_backlog[$];
    res_t        pin_expected[$];

    int unsigned beats_total = 0;
    int unsigned beats_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        calm;

    // Player model state, all clear out of reset
    logic [31:0] queued_bits = '0;
    logic [7:0]  queued_reps = '0;
    logic [31:0] playing_bits = '0;
    logic [7:0]  playing_reps = '0;
    logic [4:0]  bit_pos = '0;
    logic        bit_pos_live = 1'b0;
    logic        pin_model = 1'b0;

    buzzer_pattern_sequencer_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pattern_word (s_pattern_word),
        .s_duration_ms  (s_duration_ms),
        .s_repeat_count (s_repeat_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_buzzer_on    (m_buzzer_on),
        .m_busy_res     (m_busy_res)
    );

    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // No idling on either side through this window of beats
    assign calm = (beats_sent >= 350) && (beats_sent < 500);

    // Mask of the low n bits, saturating to all ones
    function automatic logic [31:0] ones_mask(input int unsigned n);
        if (n >= 32) begin
            return '1;
        end
        return (32'd1 << n) - 32'd1;
    endfunction

    function automatic logic [4:0] leading_one(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                pos = 5'(i);
                break;
            end
        end
        return pos;
    endfunction

    // Advance the player model by one command beat and return the pin and busy levels
    function automatic res_t play_command(input cmd_beat_t b);
        int unsigned k_cnt;
        int unsigned j_cnt;
        logic        dropped;
        res_t        r;
        k_cnt   = (32'(b.dur) * 16) / 1000;
        j_cnt   = (32'(b.dur) * 32) / 1000;
        dropped = 1'b0;
        case (b.cmd)
            CMD_TICK: begin
                // Load the pending request once nothing plays; drop an empty one
                if (queued_reps != 0 && playing_reps == 0) begin
                    playing_bits = queued_bits;
                    playing_reps = queued_reps;
                    queued_reps  = '0;
                    if (playing_bits == 0) begin
                        playing_reps = '0;
                        dropped      = 1'b1;
                    end
                end
                if (!dropped) begin
                    if (playing_reps == 0) begin
                        pin_model = 1'b0;
                    end else begin
                        if (!bit_pos_live) begin
                            bit_pos   = leading_one(playing_bits);
                            pin_model = 1'b1;
                        end else begin
                            pin_model = playing_bits[bit_pos];
                        end
                        if (bit_pos == 0) begin
                            bit_pos_live = 1'b0;
                            playing_reps = playing_reps - 8'd1;
                        end else begin
                            bit_pos      = bit_pos - 5'd1;
                            bit_pos_live = 1'b1;
                        end
                    end
                end
            end
            CMD_DURATION: begin
                queued_bits = ones_mask(k_cnt);
                queued_reps = 8'd1;
            end
            CMD_NTIMES: begin
                queued_bits = ones_mask(j_cnt) ^ ones_mask(k_cnt);
                queued_reps = b.reps;
            end
            default: begin
                queued_bits = b.word;
                queued_reps = 8'd1;
            end
        endcase
        r.buzzer_on = pin_model;
        r.busy      = (queued_reps != 0) || (playing_reps != 0);
        return r;
    endfunction

    task automatic add_beat(input cmd_t c, input logic [31:0] w, input logic [10:0] d,
                            input logic [7:0] n);
        cmd_beat_t b;
        b.cmd  = c;
        b.word = w;
        b.dur  = d;
        b.reps = n;
        cmd_backlog.push_back(b);
    endtask

    // Random request with content biased towards short, playable patterns
    task automatic add_random_request();
        cmd_t        c;
        logic [31:0] w;
        logic [10:0] d;
        logic [7:0]  n;
        int unsigned pick;
        pick = $urandom_range(0, 2);
        c = (pick == 0) ? CMD_DURATION : ((pick == 1) ? CMD_NTIMES : CMD_PATTERN);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            w = '0;
        end else if (pick < 55) begin
            w = $urandom() >> $urandom_range(22, 31);
        end else begin
            w = $urandom();
        end
        d = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(0, 400))
                                        : 11'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            n = 8'($urandom_range(1, 3));
        end else if (pick < 90) begin
            n = '0;
        end else if (pick < 97) begin
            n = 8'($urandom_range(0, 255)) & 8'h87;
        end else begin
            n = 8'($urandom_range(0, 255));
        end
        add_beat(c, w, d, n);
    endtask

    // Fill the backlog, release reset, then wait for every result
    initial begin
        int unsigned burst;
        // Directed: idle tick, empty patterns, zero repeats, queued request, saturation
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_PATTERN, 32'h0000_0001, '0, '0);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_PATTERN, 32'h0000_0000, '0, '0);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_DURATION, '0, 11'd0, '0);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_NTIMES, '0, 11'd190, 8'd0);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_NTIMES, '0, 11'd125, 8'd2);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_DURATION, '0, 11'd63, '0);
        for (int i = 0; i < 9; i++) begin
            add_beat(CMD_TICK, '0, '0, '0);
        end
        add_beat(CMD_NTIMES, '1, 11'd2047, 8'd255);
        add_beat(CMD_TICK, '0, '0, '0);
        add_beat(CMD_DURATION, '1, 11'd2047, '1);
        // Random: requests with bursts of ticks, fields unused by a command carry junk
        while (cmd_backlog.size() < 25 + RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 35) begin
                add_random_request();
            end else begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst; i++) begin
                    add_beat(CMD_TICK, $urandom(), 11'($urandom_range(0, 2047)),
                             8'($urandom_range(0, 255)));
                end
            end
        end
        beats_total = cmd_backlog.size();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (beats_sent < beats_total || pin_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pin_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Drive command beats; hold each until accepted, predict on acceptance
    always @(posedge aclk) begin
        cmd_beat_t b;
        cmd_beat_t sent;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent.cmd  = cmd_t'(s_command);
                sent.word = s_pattern_word;
                sent.dur  = s_duration_ms;
                sent.reps = s_repeat_count;
                pin_expected.push_back(play_command(sent));
                beats_sent <= beats_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                    b = cmd_backlog.pop_front();
                    s_valid        <= 1'b1;
                    s_command      <= b.cmd;
                    s_pattern_word <= b.word;
                    s_duration_ms  <= b.dur;
                    s_repeat_count <= b.reps;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random, with one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 120) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pin_expected.size() == 0) begin
                $display("%0t: result beat with none expected, got buzzer_on %0b busy %0b",
                         $time, m_buzzer_on, m_busy_res);
                mismatches = mismatches + 1;
            end else begin
                want = pin_expected.pop_front();
                if (m_buzzer_on !== want.buzzer_on) begin
                    $display("%0t: buzzer_on expected %0b, got %0b",
                             $time, want.buzzer_on, m_buzzer_on);
                    mismatches = mismatches + 1;
                end
                if (m_busy_res !== want.busy) begin
                    $display("%0t: busy_res expected %0b, got %0b",
                             $time, want.busy, m_busy_res);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire

/* buzzer_pattern_sequencer_top.f */
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_req_decode.sv
hdl/bps_player.sv
hdl/buzzer_pattern_sequencer_top.sv
hdl/bps_checker.sv
sim/buzzer_pattern_sequencer_top_tb.sv
